@@ rtl/wtc_pkg.sv @@
// Shared types, constants and lookup tables for the weighted timeslice unit.
// No dependencies; every other file depends on this package.
`timescale 1ns / 1ps

package wtc_pkg;

  localparam int OPC_W   = 2;
  localparam int IDX_W   = 6;
  localparam int TIME_W  = 32;
  localparam int QW_W    = 23;
  localparam int QC_W    = 7;
  localparam int RES_W   = 64;
  localparam int WGT_W   = 17;
  localparam int LOAD_W  = 24;
  localparam int FACT_W  = 49;
  localparam int SH_W    = 6;
  localparam int MUL_W   = 32;
  localparam int DATA_W  = 32;
  localparam int REG_W   = 2;
  localparam int LAT_W   = 32;
  localparam int GRAN_W  = 16;

  localparam int MAX_TASKS   = 64;
  localparam int NICE_LEVELS = 40;

  localparam logic [IDX_W-1:0]  NICE_MAX     = IDX_W'(NICE_LEVELS - 1);
  localparam logic [WGT_W-1:0]  NICE0_WEIGHT = WGT_W'(1024);
  localparam logic [MUL_W-1:0]  INV_MAX      = '1;
  localparam logic [SH_W-1:0]   SH_INIT      = SH_W'(32);

  localparam logic [LAT_W-1:0]  LATENCY_RST   = LAT_W'(64);
  localparam logic [GRAN_W-1:0] MIN_GRAN_RST  = GRAN_W'(8);
  localparam logic [QC_W-1:0]   LAT_TASKS_RST = QC_W'(8);

  typedef enum logic [OPC_W-1:0] {
    OP_TO_VIRT = 2'd0,
    OP_SLICE   = 2'd1,
    OP_VSLICE  = 2'd2,
    OP_NONE    = 2'd3
  } wtc_op_e;

  typedef enum logic [REG_W-1:0] {
    REG_LATENCY   = 2'd0,
    REG_MIN_GRAN  = 2'd1,
    REG_LAT_TASKS = 2'd2
  } wtc_reg_e;

  typedef struct packed {
    logic              start;
    logic [LOAD_W-1:0] divisor;
  } wtc_div_req_t;

  typedef struct packed {
    logic             done;
    logic [MUL_W-1:0] quot;
  } wtc_div_rsp_t;

  function automatic logic [WGT_W-1:0] wtc_weight(input logic [IDX_W-1:0] idx);
    logic [WGT_W-1:0] w;
    case (idx)
      6'd0:  w = 17'd88761;  6'd1:  w = 17'd71755;  6'd2:  w = 17'd56483;
      6'd3:  w = 17'd46273;  6'd4:  w = 17'd36291;  6'd5:  w = 17'd29154;
      6'd6:  w = 17'd23254;  6'd7:  w = 17'd18705;  6'd8:  w = 17'd14949;
      6'd9:  w = 17'd11916;  6'd10: w = 17'd9548;   6'd11: w = 17'd7620;
      6'd12: w = 17'd6100;   6'd13: w = 17'd4904;   6'd14: w = 17'd3906;
      6'd15: w = 17'd3121;   6'd16: w = 17'd2501;   6'd17: w = 17'd1991;
      6'd18: w = 17'd1586;   6'd19: w = 17'd1277;   6'd20: w = 17'd1024;
      6'd21: w = 17'd820;    6'd22: w = 17'd655;    6'd23: w = 17'd526;
      6'd24: w = 17'd423;    6'd25: w = 17'd335;    6'd26: w = 17'd272;
      6'd27: w = 17'd215;    6'd28: w = 17'd172;    6'd29: w = 17'd137;
      6'd30: w = 17'd110;    6'd31: w = 17'd87;     6'd32: w = 17'd70;
      6'd33: w = 17'd56;     6'd34: w = 17'd45;     6'd35: w = 17'd36;
      6'd36: w = 17'd29;     6'd37: w = 17'd23;     6'd38: w = 17'd18;
      default: w = 17'd15;
    endcase
    return w;
  endfunction

  function automatic logic [MUL_W-1:0] wtc_recip(input logic [IDX_W-1:0] idx);
    logic [MUL_W-1:0] r;
    case (idx)
      6'd0:  r = 32'd48388;     6'd1:  r = 32'd59856;     6'd2:  r = 32'd76040;
      6'd3:  r = 32'd92818;     6'd4:  r = 32'd118348;    6'd5:  r = 32'd147320;
      6'd6:  r = 32'd184698;    6'd7:  r = 32'd229616;    6'd8:  r = 32'd287308;
      6'd9:  r = 32'd360437;    6'd10: r = 32'd449829;    6'd11: r = 32'd563644;
      6'd12: r = 32'd704093;    6'd13: r = 32'd875809;    6'd14: r = 32'd1099582;
      6'd15: r = 32'd1376151;   6'd16: r = 32'd1717300;   6'd17: r = 32'd2157191;
      6'd18: r = 32'd2708050;   6'd19: r = 32'd3363326;   6'd20: r = 32'd4194304;
      6'd21: r = 32'd5237765;   6'd22: r = 32'd6557202;   6'd23: r = 32'd8165337;
      6'd24: r = 32'd10153587;  6'd25: r = 32'd12820798;  6'd26: r = 32'd15790321;
      6'd27: r = 32'd19976592;  6'd28: r = 32'd24970740;  6'd29: r = 32'd31350126;
      6'd30: r = 32'd39045157;  6'd31: r = 32'd49367440;  6'd32: r = 32'd61356676;
      6'd33: r = 32'd76695844;  6'd34: r = 32'd95443717;  6'd35: r = 32'd119304647;
      6'd36: r = 32'd148102320; 6'd37: r = 32'd186737708; 6'd38: r = 32'd238609294;
      default: r = 32'd286331153;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/wtc_intf.sv @@
// Valid/ready channel interfaces: request input, result output, config write.
// Depends on wtc_pkg for field widths.
`timescale 1ns / 1ps

interface wtc_in_if;
  logic                           valid;
  logic                           ready;
  logic [wtc_pkg::OPC_W-1:0]      opcode;
  logic [wtc_pkg::IDX_W-1:0]      nice_index;
  logic [wtc_pkg::TIME_W-1:0]     time_amount;
  logic [wtc_pkg::QW_W-1:0]       queue_weight;
  logic [wtc_pkg::QC_W-1:0]       queued_count;
  logic                           task_queued;

  modport source (output valid, opcode, nice_index, time_amount, queue_weight,
                  queued_count, task_queued, input ready);
  modport sink   (input valid, opcode, nice_index, time_amount, queue_weight,
                  queued_count, task_queued, output ready);
endinterface

interface wtc_out_if;
  logic                        valid;
  logic                        ready;
  logic [wtc_pkg::RES_W-1:0]   scaled_time;

  modport source (output valid, scaled_time, input ready);
  modport sink   (input valid, scaled_time, output ready);
endinterface

interface wtc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [wtc_pkg::REG_W-1:0]   index;
  logic [wtc_pkg::DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/weighted_timeslice_calculator_unit.sv @@
// Top level: config registers, sequencer and datapath of the timeslice unit.
// Depends on wtc_pkg, wtc_intf, wtc_div and wtc_mul.
`timescale 1ns / 1ps

// One request at a time; in_req.ready is high only while the sequencer is idle.
// A request goes straight to the output stage when the weight is the nice-0 weight
// (opcode 0) or the opcode is unknown. Other opcode 0 requests scale by the weight
// reciprocal; a timeslice first waits on the bit-serial divider for the load reciprocal,
// and a virtual timeslice adds the to-virtual pass. The factor has a one-bit-a-cycle
// normalize, and all products go through one registered 32x32 multiplier. The result
// sits in an output register, so the next request is taken while it waits.
// Config writes are taken any cycle and must only be issued while idle.
module weighted_timeslice_calculator_unit (
  input  logic   clk_i,
  input  logic   rst_ni,
  wtc_in_if.sink    in_req,
  wtc_out_if.source out_res,
  wtc_cfg_if.sink   cfg_wr
);
  import wtc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_PERIOD = 11'b000_0000_0010,
    S_PLATCH = 11'b000_0000_0100,
    S_DIVW   = 11'b000_0000_1000,
    S_FMUL   = 11'b000_0001_0000,
    S_FLATCH = 11'b000_0010_0000,
    S_NORM   = 11'b000_0100_0000,
    S_MLO    = 11'b000_1000_0000,
    S_MHI    = 11'b001_0000_0000,
    S_COMB   = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } wtc_state_e;

  wtc_state_e        state_q, state_d;

  logic [LAT_W-1:0]  lat_q;
  logic [GRAN_W-1:0] gran_q;
  logic [QC_W-1:0]   ltc_q;

  logic              out_vld_q;
  logic [RES_W-1:0]  out_data_q;

  wtc_op_e           op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [QC_W-1:0]   count_q;
  logic [LOAD_W-1:0] load_q;
  logic              pass_q;
  logic [RES_W-1:0]  x_q;
  logic [WGT_W-1:0]  fa_q;
  logic [MUL_W-1:0]  fb_q;
  logic [FACT_W-1:0] fact_q;
  logic [SH_W-1:0]   sh_q;
  logic [RES_W-1:0]  lo_q;
  logic [RES_W-1:0]  res_q;

  logic [IDX_W-1:0]  idx_in;
  logic [WGT_W-1:0]  w_in;
  logic [QC_W-1:0]   cnt_clamp;
  logic [QC_W-1:0]   count_in;
  logic [LOAD_W-1:0] load_in;
  logic [WGT_W-1:0]  w_cur;
  logic [MUL_W-1:0]  recip_cur;
  logic              in_acc;
  logic              out_load;

  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [2*MUL_W-1:0] prod;

  logic [RES_W+MUL_W-1:0] full_sum;
  logic [RES_W+MUL_W-1:0] full_shr;

  wtc_div_req_t div_req;
  wtc_div_rsp_t div_rsp;

  wtc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  wtc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // request decode
  assign idx_in    = (in_req.nice_index > NICE_MAX) ? NICE_MAX : in_req.nice_index;
  assign w_in      = wtc_weight(idx_in);
  assign cnt_clamp = (in_req.queued_count > QC_W'(MAX_TASKS)) ? QC_W'(MAX_TASKS)
                                                              : in_req.queued_count;
  assign count_in  = cnt_clamp + QC_W'(!in_req.task_queued);
  assign load_in   = LOAD_W'(in_req.queue_weight)
                   + (in_req.task_queued ? LOAD_W'(0) : LOAD_W'(w_in));

  assign w_cur     = wtc_weight(idx_q);
  assign recip_cur = wtc_recip(idx_q);

  assign in_req.ready = (state_q == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign cfg_wr.ready = 1'b1;

  assign out_load        = (state_q == S_FIN) && (!out_vld_q || out_res.ready);
  assign out_res.valid       = out_vld_q;
  assign out_res.scaled_time = out_data_q;

  assign div_req.start   = (state_q == S_PERIOD);
  assign div_req.divisor = load_q;

  // x * fact, 96 bits exact, then right shift by sh (1..32)
  assign full_sum = {prod, {MUL_W{1'b0}}} + {{MUL_W{1'b0}}, lo_q};
  assign full_shr = full_sum >> sh_q;

  always_comb begin
    mul_a = fact_q[MUL_W-1:0];
    mul_b = x_q[MUL_W-1:0];
    case (state_q)
      S_PERIOD: begin
        mul_a = MUL_W'(gran_q);
        mul_b = MUL_W'(count_q);
      end
      S_FMUL: begin
        mul_a = MUL_W'(fa_q);
        mul_b = fb_q;
      end
      S_MHI: begin
        mul_a = fact_q[MUL_W-1:0];
        mul_b = x_q[RES_W-1:MUL_W];
      end
      default: begin
        mul_a = fact_q[MUL_W-1:0];
        mul_b = x_q[MUL_W-1:0];
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (wtc_op_e'(in_req.opcode))
            OP_TO_VIRT: state_d = (w_in == NICE0_WEIGHT) ? S_FIN : S_FMUL;
            OP_SLICE,
            OP_VSLICE:  state_d = S_PERIOD;
            default:    state_d = S_FIN;
          endcase
        end
      end
      S_PERIOD: state_d = S_PLATCH;
      S_PLATCH: state_d = S_DIVW;
      S_DIVW:   state_d = div_rsp.done ? S_FMUL : S_DIVW;
      S_FMUL:   state_d = S_FLATCH;
      S_FLATCH: state_d = S_NORM;
      S_NORM: begin
        if (!((|fact_q[FACT_W-1:MUL_W]) && (sh_q > SH_W'(1)))) begin
          state_d = S_MLO;
        end
      end
      S_MLO:  state_d = S_MHI;
      S_MHI:  state_d = S_COMB;
      S_COMB: begin
        // virtual timeslice runs the to-virtual pass after the slice unless its weight is the nice-0 weight
        if (!pass_q && (op_q == OP_VSLICE) && (w_cur != NICE0_WEIGHT)) begin
          state_d = S_FMUL;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN:   state_d = out_load ? S_IDLE : S_FIN;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      lat_q     <= LATENCY_RST;
      gran_q    <= MIN_GRAN_RST;
      ltc_q     <= LAT_TASKS_RST;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_res.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_wr.valid) begin
        case (wtc_reg_e'(cfg_wr.index))
          REG_LATENCY:   lat_q  <= cfg_wr.data[LAT_W-1:0];
          REG_MIN_GRAN:  gran_q <= cfg_wr.data[GRAN_W-1:0];
          REG_LAT_TASKS: ltc_q  <= cfg_wr.data[QC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res_q;
    end
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_q    <= wtc_op_e'(in_req.opcode);
          idx_q   <= idx_in;
          count_q <= count_in;
          load_q  <= load_in;
          x_q     <= RES_W'(in_req.time_amount);
          res_q   <= (wtc_op_e'(in_req.opcode) == OP_TO_VIRT)
                     ? RES_W'(in_req.time_amount) : '0;
          fa_q    <= NICE0_WEIGHT;
          fb_q    <= wtc_recip(idx_in);
          pass_q  <= !((wtc_op_e'(in_req.opcode) == OP_SLICE) ||
                       (wtc_op_e'(in_req.opcode) == OP_VSLICE));
        end
      end
      S_PLATCH: begin
        x_q <= (count_q > ltc_q) ? RES_W'(prod[MUL_W-1:0]) : RES_W'(lat_q);
      end
      S_DIVW: begin
        fa_q <= w_cur;
        fb_q <= (load_q == '0) ? INV_MAX : div_rsp.quot;
      end
      S_FLATCH: begin
        fact_q <= prod[FACT_W-1:0];
        sh_q   <= SH_INIT;
      end
      S_NORM: begin
        if ((|fact_q[FACT_W-1:MUL_W]) && (sh_q > SH_W'(1))) begin
          fact_q <= fact_q >> 1;
          sh_q   <= sh_q - SH_W'(1);
        end
      end
      S_MHI: begin
        lo_q <= prod;
      end
      S_COMB: begin
        res_q  <= full_shr[RES_W-1:0];
        x_q    <= full_shr[RES_W-1:0];
        fa_q   <= NICE0_WEIGHT;
        fb_q   <= recip_cur;
        pass_q <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/wtc_div.sv @@
// Restoring divider, one quotient bit per cycle: 0xFFFFFFFF / divisor.
// Depends on wtc_pkg. A zero divisor yields an all-ones quotient.
`timescale 1ns / 1ps

module wtc_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wtc_pkg::wtc_div_req_t req_i,
  output wtc_pkg::wtc_div_rsp_t rsp_o
);
  import wtc_pkg::*;

  localparam int CNT_W = $clog2(MUL_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [LOAD_W-1:0] rem_q;
  logic [LOAD_W-1:0] dvs_q;
  logic [MUL_W-1:0]  quo_q;
  logic [LOAD_W:0]   trial;
  logic [LOAD_W:0]   diff;
  logic              ge;

  assign trial = {rem_q, quo_q[MUL_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(MUL_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // dividend bits shift out of the top of quo_q as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      quo_q <= INV_MAX;
    end else if (busy_q) begin
      rem_q <= ge ? diff[LOAD_W-1:0] : trial[LOAD_W-1:0];
      quo_q <= {quo_q[MUL_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

@@ rtl/wtc_mul.sv @@
// Shared 32x32 multiplier with a registered 64-bit product.
// Depends on wtc_pkg.
`timescale 1ns / 1ps

module wtc_mul (
  input  logic                          clk_i,
  input  logic [wtc_pkg::MUL_W-1:0]     a_i,
  input  logic [wtc_pkg::MUL_W-1:0]     b_i,
  output logic [2*wtc_pkg::MUL_W-1:0]   p_o
);
  import wtc_pkg::*;

  logic [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for weighted_timeslice_calculator_unit.
// Drives random and directed requests against an internal predictor of the fair-share math.
// Depends on wtc_pkg and the wtc_*_if interfaces from rtl.
`timescale 1ns / 1ps

module tb_top;
  import wtc_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned PHASE_REQS      = 225;
  localparam int unsigned RAND_PHASES     = 6;

  typedef struct packed {
    wtc_op_e             opcode;
    logic [IDX_W-1:0]    nice_index;
    logic [TIME_W-1:0]   time_amount;
    logic [QW_W-1:0]     queue_weight;
    logic [QC_W-1:0]     queued_count;
    logic                task_queued;
  } slice_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wtc_in_if  in_req ();
  wtc_out_if out_res ();
  wtc_cfg_if cfg_wr ();

  weighted_timeslice_calculator_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the config registers
  logic [LAT_W-1:0]  latency_q   = LATENCY_RST;
  logic [GRAN_W-1:0] min_gran_q  = MIN_GRAN_RST;
  logic [QC_W-1:0]   lat_tasks_q = LAT_TASKS_RST;

  slice_req_t        pending_reqs [$];
  logic [RES_W-1:0]  expected_times [$];
  slice_req_t        offered_req;
  logic [RES_W-1:0]  want_time;
  int unsigned       issued_count   = 0;
  int unsigned       accepted_count = 0;
  int unsigned       error_count    = 0;
  int unsigned       cycle_count    = 0;
  int unsigned       send_gap       = 0;
  int unsigned       recv_gap       = 0;
  int unsigned       hold_left      = 0;
  int unsigned       hold_off_asks  = 0;
  int unsigned       hold_off_seen  = 0;
  bit                no_idling      = 1'b0;

  function automatic logic [31:0] weight_of(input int unsigned idx);
    case (idx)
      0: return 88761;  1: return 71755;  2: return 56483;  3: return 46273;
      4: return 36291;  5: return 29154;  6: return 23254;  7: return 18705;
      8: return 14949;  9: return 11916;  10: return 9548;  11: return 7620;
      12: return 6100;  13: return 4904;  14: return 3906;  15: return 3121;
      16: return 2501;  17: return 1991;  18: return 1586;  19: return 1277;
      20: return 1024;  21: return 820;   22: return 655;   23: return 526;
      24: return 423;   25: return 335;   26: return 272;   27: return 215;
      28: return 172;   29: return 137;   30: return 110;   31: return 87;
      32: return 70;    33: return 56;    34: return 45;    35: return 36;
      36: return 29;    37: return 23;    38: return 18;    default: return 15;
    endcase
  endfunction

  function automatic logic [31:0] reciprocal_of(input int unsigned idx);
    case (idx)
      0: return 48388;      1: return 59856;      2: return 76040;
      3: return 92818;      4: return 118348;     5: return 147320;
      6: return 184698;     7: return 229616;     8: return 287308;
      9: return 360437;     10: return 449829;    11: return 563644;
      12: return 704093;    13: return 875809;    14: return 1099582;
      15: return 1376151;   16: return 1717300;   17: return 2157191;
      18: return 2708050;   19: return 3363326;   20: return 4194304;
      21: return 5237765;   22: return 6557202;   23: return 8165337;
      24: return 10153587;  25: return 12820798;  26: return 15790321;
      27: return 19976592;  28: return 24970740;  29: return 31350126;
      30: return 39045157;  31: return 49367440;  32: return 61356676;
      33: return 76695844;  34: return 95443717;  35: return 119304647;
      36: return 148102320; 37: return 186737708; 38: return 238609294;
      default: return 286331153;
    endcase
  endfunction

  // x * w / load with inv ~ 2^32/load; factor normalized into 32 bits, exact product
  function automatic logic [63:0] ratio_scale(input logic [63:0] x, input logic [31:0] w,
                                              input logic [31:0] inv);
    logic [63:0] fact;
    logic [95:0] prod;
    int unsigned sh;
    fact = 64'(w) * 64'(inv);
    sh = 32;
    while (fact[63:32] != 0 && sh > 1) begin
      fact = fact >> 1;
      sh--;
    end
    prod = 96'(x) * 96'(fact[31:0]);
    return 64'(prod >> sh);
  endfunction

  function automatic logic [63:0] virtual_time_of(input logic [63:0] t, input int unsigned idx);
    if (weight_of(idx) == 32'(NICE0_WEIGHT)) return t;
    return ratio_scale(t, 32'(NICE0_WEIGHT), reciprocal_of(idx));
  endfunction

  function automatic logic [63:0] slice_of(input slice_req_t r, input int unsigned idx);
    logic [31:0] w;
    logic [63:0] count;
    logic [63:0] load;
    logic [63:0] period;
    logic [31:0] inv;
    w = weight_of(idx);
    count = (r.queued_count > MAX_TASKS) ? 64'(MAX_TASKS) : 64'(r.queued_count);
    load = 64'(r.queue_weight);
    if (!r.task_queued) begin
      count = count + 1;
      load = load + 64'(w);
    end
    period = (count > 64'(lat_tasks_q)) ? 64'(min_gran_q) * count : 64'(latency_q);
    if (load >= 64'hFFFF_FFFF) inv = 32'd1;
    else if (load == 0) inv = INV_MAX;
    else inv = 32'(64'hFFFF_FFFF / load);
    return ratio_scale(period, w, inv);
  endfunction

  function automatic logic [RES_W-1:0] predict_scaled_time(input slice_req_t r);
    int unsigned idx;
    idx = (r.nice_index > NICE_MAX) ? int'(NICE_MAX) : int'(r.nice_index);
    case (r.opcode)
      OP_TO_VIRT: return virtual_time_of(64'(r.time_amount), idx);
      OP_SLICE:   return slice_of(r, idx);
      OP_VSLICE:  return virtual_time_of(slice_of(r, idx), idx);
      default:    return '0;
    endcase
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned roll;
    if (no_idling) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic slice_req_t make_req(input wtc_op_e op, input int unsigned idx,
                                          input logic [TIME_W-1:0] t,
                                          input logic [QW_W-1:0] qw,
                                          input logic [QC_W-1:0] qc, input logic queued);
    slice_req_t r;
    r.opcode = op;
    r.nice_index = IDX_W'(idx);
    r.time_amount = t;
    r.queue_weight = qw;
    r.queued_count = qc;
    r.task_queued = queued;
    return r;
  endfunction

  function automatic slice_req_t random_req();
    slice_req_t r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    r.opcode = (roll < 5) ? OP_NONE : wtc_op_e'(OPC_W'($urandom_range(0, 2)));
    r.nice_index = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(40, 63))
                                              : IDX_W'($urandom_range(0, 39));
    roll = $urandom_range(0, 99);
    if (roll < 8) r.time_amount = '0;
    else if (roll < 16) r.time_amount = '1;
    else if (roll < 40) r.time_amount = TIME_W'($urandom_range(0, 5000));
    else r.time_amount = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 6) r.queue_weight = '0;
    else if (roll < 10) r.queue_weight = '1;
    else if (roll < 45) r.queue_weight = QW_W'($urandom);
    else r.queue_weight = QW_W'($urandom_range(0, 300000));
    roll = $urandom_range(0, 99);
    if (roll < 65) r.queued_count = QC_W'($urandom_range(0, 70));
    else r.queued_count = QC_W'($urandom);
    r.task_queued = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic queue_req(input slice_req_t r);
    pending_reqs.push_back(r);
    issued_count++;
  endtask

  task automatic write_reg(input wtc_reg_e idx, input logic [DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data <= value;
    do @(posedge clk_i); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
    case (idx)
      REG_LATENCY:   latency_q = value;
      REG_MIN_GRAN:  min_gran_q = value[GRAN_W-1:0];
      REG_LAT_TASKS: lat_tasks_q = value[QC_W-1:0];
      default: ;
    endcase
  endtask

  // wait until every request went in and every result came back
  task automatic drain();
    while (accepted_count != issued_count || expected_times.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_req.valid <= 1'b0;
      in_req.opcode <= '0;
      in_req.nice_index <= '0;
      in_req.time_amount <= '0;
      in_req.queue_weight <= '0;
      in_req.queued_count <= '0;
      in_req.task_queued <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        expected_times.push_back(predict_scaled_time(offered_req));
        accepted_count++;
      end
      if (!in_req.valid || in_req.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_req.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          offered_req = pending_reqs.pop_front();
          in_req.valid <= 1'b1;
          in_req.opcode <= offered_req.opcode;
          in_req.nice_index <= offered_req.nice_index;
          in_req.time_amount <= offered_req.time_amount;
          in_req.queue_weight <= offered_req.queue_weight;
          in_req.queued_count <= offered_req.queued_count;
          in_req.task_queued <= offered_req.task_queued;
          send_gap = idle_gap();
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_res.ready <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        if (expected_times.size() == 0) begin
          $error("scaled_time: unexpected result, actual 0x%0h", out_res.scaled_time);
          error_count++;
        end else begin
          want_time = expected_times.pop_front();
          if (out_res.scaled_time !== want_time) begin
            $error("scaled_time mismatch: expected 0x%0h, actual 0x%0h",
                   want_time, out_res.scaled_time);
            error_count++;
          end
        end
      end
      if (hold_off_seen != hold_off_asks) begin
        hold_off_seen = hold_off_asks;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_res.ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= 1'b1;
        recv_gap = idle_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_req.valid = 1'b0;
    in_req.opcode = '0;
    in_req.nice_index = '0;
    in_req.time_amount = '0;
    in_req.queue_weight = '0;
    in_req.queued_count = '0;
    in_req.task_queued = 1'b0;
    out_res.ready = 1'b0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = REG_LATENCY;
    cfg_wr.data = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed corners on reset config
    queue_req(make_req(OP_TO_VIRT, 20, '1, '0, '0, 1'b0));        // nice-0 weight passes through
    queue_req(make_req(OP_TO_VIRT, 0, '1, '0, '0, 1'b0));
    queue_req(make_req(OP_TO_VIRT, 39, '1, '1, '1, 1'b1));
    queue_req(make_req(OP_TO_VIRT, 63, 32'd12345, '0, '0, 1'b0)); // index clamps to 39
    queue_req(make_req(OP_TO_VIRT, 7, '0, '0, '0, 1'b0));
    queue_req(make_req(OP_SLICE, 20, '0, '0, '0, 1'b1));          // empty load
    queue_req(make_req(OP_SLICE, 0, '0, '1, '1, 1'b0));           // count clamps to max tasks
    queue_req(make_req(OP_SLICE, 39, '0, '0, '0, 1'b0));
    queue_req(make_req(OP_SLICE, 10, '0, 23'd9548, QC_W'(8), 1'b1));
    queue_req(make_req(OP_SLICE, 10, '0, 23'd9548, QC_W'(8), 1'b0));
    queue_req(make_req(OP_SLICE, 45, '0, 23'd1, QC_W'(64), 1'b1));
    queue_req(make_req(OP_VSLICE, 0, '0, 23'd88761, QC_W'(1), 1'b1));
    queue_req(make_req(OP_VSLICE, 39, '0, '0, '0, 1'b0));
    queue_req(make_req(OP_VSLICE, 20, '0, 23'd5000, QC_W'(20), 1'b0));
    queue_req(make_req(OP_VSLICE, 63, '0, '1, '1, 1'b1));
    queue_req(make_req(OP_NONE, 5, '1, '1, '1, 1'b1));
    queue_req(make_req(OP_NONE, 0, '0, '0, '0, 1'b0));
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_LATENCY, '1);
          write_reg(REG_MIN_GRAN, DATA_W'(16'hFFFF));
          write_reg(REG_LAT_TASKS, '0);
        end
        1: begin
          write_reg(REG_LATENCY, '0);
          write_reg(REG_MIN_GRAN, '0);
          write_reg(REG_LAT_TASKS, DATA_W'(MAX_TASKS));
        end
        default: begin
          write_reg(REG_LATENCY, ($urandom_range(0, 1) != 0) ? $urandom
                                                             : $urandom_range(0, 5000));
          write_reg(REG_MIN_GRAN, $urandom_range(0, 65535));
          write_reg(REG_LAT_TASKS, $urandom_range(0, MAX_TASKS));
        end
      endcase
      no_idling = (ph == 1);
      for (int n = 0; n < PHASE_REQS; n++) queue_req(random_req());
      if (ph == 0 || ph == 3) begin
        // back-pressure the output long enough to stall the request side
        repeat (30) @(posedge clk_i);
        hold_off_asks++;
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/wtc_pkg.sv
rtl/wtc_intf.sv
rtl/wtc_div.sv
rtl/wtc_mul.sv
rtl/weighted_timeslice_calculator_unit.sv
tb/tb_top.sv
